>>> rtl/joystick_deadzone_polar_map_unit_defines.svh
// Assertion macros used by the top-level RTL file.
`ifndef JOYSTICK_DEADZONE_POLAR_MAP_UNIT_DEFINES_SVH
`define JOYSTICK_DEADZONE_POLAR_MAP_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JDPM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JDPM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/jdpm_pkg.sv
package jdpm_pkg;

   // Register reset value and full-scale axis count.
   localparam logic [14:0] DEAD_ZONE_RESET = 15'd3200;
   localparam logic [14:0] FULL_SCALE      = 15'd32767;
   localparam logic [14:0] Q14_ONE         = 15'd16384;

   // Angle constants, in units of 2^-20 rad inside and 2^-13 rad outside.
   localparam int          CORDIC_ITERS = 20;
   localparam logic [21:0] PI_Q20       = 22'd3294199;
   localparam logic [15:0] ANGLE_MAX    = 16'd25736;
   localparam logic [15:0] HALF_PI_OUT  = 16'd12868;

   // atan(2^-i) in units of 2^-20 rad, rounded to nearest.
   localparam logic [20:0] ATAN_TAB [CORDIC_ITERS] = '{
      21'd823550, 21'd486170, 21'd256879, 21'd130396, 21'd65451,
      21'd32757,  21'd16383,  21'd8192,   21'd4096,   21'd2048,
      21'd1024,   21'd512,    21'd256,    21'd128,    21'd64,
      21'd32,     21'd16,     21'd8,      21'd4,      21'd2
   };

   // Normalized axis pair that travels down the pipeline.
   typedef struct packed {
      logic signed [15:0] y;
      logic signed [15:0] x;
   } norm_pair_type;

endpackage

>>> rtl/jdpm_dead_zone.sv
module jdpm_dead_zone (
   input  logic               clock,
   input  logic               en,
   input  logic signed [15:0] raw,
   input  logic [14:0]        dead_zone,
   output logic signed [15:0] norm
);

   localparam int QW = 15;
   localparam int RW = 29;

   logic [14:0]        span;
   logic signed [16:0] v_ext;
   logic signed [16:0] inv_ext;
   logic signed [16:0] dz_ext;
   logic               pos;
   logic               negc;
   logic [14:0]        num_in;
   logic [14:0]        num_ff;
   logic               neg_ff;
   logic               nz_ff;
   logic [RW-1:0]      rem_ff [QW-1];
   logic [QW-1:0]      q_ff [QW];
   logic               neg_d_ff [QW];
   logic               nz_d_ff [QW];
   logic signed [15:0] qs;
   logic signed [15:0] norm_in;
   logic signed [15:0] norm_ff;

   // Span of the live range above the dead zone; the user must keep it stable while items run.
   assign span = jdpm_pkg::FULL_SCALE - dead_zone;

   // Dead zone test. The negative side uses ~v, which equals -v - 1.
   assign v_ext   = 17'(raw);
   assign inv_ext = 17'(~raw);
   assign dz_ext  = signed'({2'b00, dead_zone});
   assign pos     = v_ext > dz_ext;
   assign negc    = inv_ext > dz_ext;

   always_comb begin
      if (pos) begin
         num_in = 15'(v_ext - dz_ext);
      end else if (negc) begin
         num_in = 15'(inv_ext - dz_ext);
      end else begin
         num_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         neg_ff <= negc;
         nz_ff  <= pos | negc;
      end
   end

   // Restoring divider, one quotient bit per stage. The dividend is
   // num * 16384 + span / 2, which is a plain concatenation.
   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [RW-1:0] rem_cur;
      logic [RW-1:0] rem_nxt;
      logic [RW-1:0] dsh;
      logic [QW-1:0] q_cur;
      logic [QW-1:0] q_nxt;
      logic          neg_cur;
      logic          nz_cur;

      if (k == 0) begin : g_first
         assign rem_cur = {num_ff, span[14:1]};
         assign q_cur   = '0;
         assign neg_cur = neg_ff;
         assign nz_cur  = nz_ff;
      end else begin : g_rest
         assign rem_cur = rem_ff[k-1];
         assign q_cur   = q_ff[k-1];
         assign neg_cur = neg_d_ff[k-1];
         assign nz_cur  = nz_d_ff[k-1];
      end

      assign dsh = RW'(span) << (QW - 1 - k);

      always_comb begin
         if (rem_cur >= dsh) begin
            rem_nxt = rem_cur - dsh;
            q_nxt   = q_cur | (QW'(1) << (QW - 1 - k));
         end else begin
            rem_nxt = rem_cur;
            q_nxt   = q_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k]     <= q_nxt;
            neg_d_ff[k] <= neg_cur;
            nz_d_ff[k]  <= nz_cur;
         end
      end

      if (k < QW - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_nxt;
            end
         end
      end
   end

   // Apply the sign; a sample inside the dead zone gives zero.
   assign qs = signed'({1'b0, q_ff[QW-1]});

   always_comb begin
      if (!nz_d_ff[QW-1]) begin
         norm_in = '0;
      end else if (neg_d_ff[QW-1]) begin
         norm_in = -qs;
      end else begin
         norm_in = qs;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         norm_ff <= norm_in;
      end
   end

   assign norm = norm_ff;

endmodule

>>> rtl/jdpm_isqrt.sv
module jdpm_isqrt #(
   parameter int W = 32
) (
   input  logic           clock,
   input  logic           en,
   input  logic [W-1:0]   arg,
   output logic [W/2-1:0] root
);

   localparam int S = W / 2;

   logic [W-1:0] v_ff [S-1];
   logic [W-1:0] res_ff [S];

   // One root bit per stage. The trial bit never overlaps the partial
   // root, so res + bit is an OR.
   for (genvar k = 0; k < S; k++) begin : g_step
      logic [W-1:0] v_cur;
      logic [W-1:0] res_cur;
      logic [W-1:0] bit_c;
      logic [W-1:0] trial;
      logic [W-1:0] v_nxt;
      logic [W-1:0] res_nxt;

      if (k == 0) begin : g_first
         assign v_cur   = arg;
         assign res_cur = '0;
      end else begin : g_rest
         assign v_cur   = v_ff[k-1];
         assign res_cur = res_ff[k-1];
      end

      assign bit_c = W'(1) << (W - 2 - 2 * k);
      assign trial = res_cur | bit_c;

      always_comb begin
         if (v_cur >= trial) begin
            v_nxt   = v_cur - trial;
            res_nxt = (res_cur >> 1) | bit_c;
         end else begin
            v_nxt   = v_cur;
            res_nxt = res_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            res_ff[k] <= res_nxt;
         end
      end

      if (k < S - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               v_ff[k] <= v_nxt;
            end
         end
      end
   end

   assign root = res_ff[S-1][S-1:0];

endmodule

>>> rtl/jdpm_cordic.sv
module jdpm_cordic (
   input  logic               clock,
   input  logic               en,
   input  logic [29:0]        wx,
   input  logic [29:0]        wy,
   input  logic               x_neg,
   input  logic               y_neg,
   output logic signed [15:0] angle
);

   localparam int N  = jdpm_pkg::CORDIC_ITERS;
   localparam int XW = 34;
   localparam int ZW = 23;

   logic signed [XW-1:0] x_ff [N];
   logic signed [XW-1:0] y_ff [N];
   logic signed [ZW-1:0] z_ff [N];
   logic                 xn_ff [N];
   logic                 yn_ff [N];
   logic signed [ZW-1:0] pi_s;
   logic signed [ZW-1:0] a_pos;
   logic signed [ZW-1:0] mag1;
   logic [ZW-2:0]        mag_in;
   logic [ZW-2:0]        mag_ff;
   logic                 yn1_ff;
   logic [ZW-1:0]        rnd_sum;
   logic [15:0]          rnd_mag;
   logic signed [15:0]   mag_clamp;
   logic signed [15:0]   angle_in;
   logic signed [15:0]   angle_ff;

   // Vectoring iterations in the first quadrant, one per stage.
   for (genvar i = 0; i < N; i++) begin : g_iter
      logic signed [XW-1:0] x_cur;
      logic signed [XW-1:0] y_cur;
      logic signed [ZW-1:0] z_cur;
      logic                 xn_cur;
      logic                 yn_cur;
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;
      logic signed [ZW-1:0] atan_s;

      if (i == 0) begin : g_first
         assign x_cur  = signed'({4'b0000, wx});
         assign y_cur  = signed'({4'b0000, wy});
         assign z_cur  = '0;
         assign xn_cur = x_neg;
         assign yn_cur = y_neg;
      end else begin : g_rest
         assign x_cur  = x_ff[i-1];
         assign y_cur  = y_ff[i-1];
         assign z_cur  = z_ff[i-1];
         assign xn_cur = xn_ff[i-1];
         assign yn_cur = yn_ff[i-1];
      end

      assign xs     = x_cur >>> i;
      assign ys     = y_cur >>> i;
      assign atan_s = signed'(ZW'(jdpm_pkg::ATAN_TAB[i]));

      always_ff @(posedge clock) begin
         if (en) begin
            if (!y_cur[XW-1]) begin
               x_ff[i] <= x_cur + ys;
               y_ff[i] <= y_cur - xs;
               z_ff[i] <= z_cur + atan_s;
            end else begin
               x_ff[i] <= x_cur - ys;
               y_ff[i] <= y_cur + xs;
               z_ff[i] <= z_cur - atan_s;
            end
            xn_ff[i] <= xn_cur;
            yn_ff[i] <= yn_cur;
         end
      end
   end

   // Restore the left half plane from the first-quadrant angle.
   assign pi_s  = signed'(ZW'(jdpm_pkg::PI_Q20));
   assign a_pos = z_ff[N-1][ZW-1] ? '0 : z_ff[N-1];
   assign mag1  = xn_ff[N-1] ? (pi_s - a_pos) : a_pos;
   assign mag_in = mag1[ZW-1] ? '0 : mag1[ZW-2:0];

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;
         yn1_ff <= yn_ff[N-1];
      end
   end

   // Round to 2^-13 rad, limit to pi and apply the sign.
   assign rnd_sum   = ZW'(mag_ff) + ZW'(64);
   assign rnd_mag   = rnd_sum[ZW-1:7];
   assign mag_clamp = (rnd_mag > jdpm_pkg::ANGLE_MAX) ? signed'(jdpm_pkg::ANGLE_MAX)
                                                      : signed'(rnd_mag);
   assign angle_in  = yn1_ff ? -mag_clamp : mag_clamp;

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

>>> rtl/joystick_deadzone_polar_map_unit.sv
// Joystick dead zone and square-to-circle polar map.
//
// The req_ channel takes one pair of raw axis samples per transaction. Each
// axis passes the dead zone and is scaled to Q14 (y with its sign reversed),
// the square is warped onto the unit disc, and the rsp_ channel returns the
// two normalized axes, the radius and the angle of the warped point. Reset
// sets the dead zone width to 3200; the user must write it through csr_wr_en
// / csr_wr_data only while no transaction is in flight; it is not enforced.
//
// The path from the req_ handshake to rsp_tvalid runs through a 15-step
// divider, a 16-step square root, a 30-step square root for the radius and a
// 20-iteration CORDIC, all fully pipelined. The block takes one transaction
// per cycle while the skid register is empty.
// Reset clears all valid bits; payload registers are left as they are.
// When rsp_tready is low, the result in the last stage moves into a skid
// register as the pipeline steps; req_tready then drops and the pipeline
// holds until the skid register drains.
`include "joystick_deadzone_polar_map_unit_defines.svh"

module joystick_deadzone_polar_map_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // raw_x[15:0], raw_y[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // norm_x[15:0], norm_y[31:16], radius[46:32],
                                    // angle[62:47], zero pad[63]
   input  logic        csr_wr_en,
   input  logic [14:0] csr_wr_data
);

   localparam int DZ_LAT   = 17;
   localparam int SQ_LAT   = 16;
   localparam int R_LAT    = 30;
   localparam int CORD_LAT = 22;
   localparam int W_T      = DZ_LAT + 3 + SQ_LAT;
   localparam int R_T      = W_T + 2 + R_LAT;
   localparam int OUT_T    = R_T + 1;
   localparam int NRM_LEN  = R_T - DZ_LAT;
   localparam int TAP      = SQ_LAT + 2;
   localparam int ANG_LEN  = R_T - (W_T + CORD_LAT);

   logic [14:0]                  dead_zone_ff;
   logic                         en;
   logic [OUT_T-1:0]             vld_ff;
   logic signed [15:0]           nx_dz;
   logic signed [15:0]           ny_dz;
   logic [15:0]                  abs_x;
   logic [15:0]                  abs_y;
   logic [29:0]                  sqx_ff;
   logic [29:0]                  sqy_ff;
   logic [31:0]                  argfx_ff;
   logic [31:0]                  argfy_ff;
   logic [15:0]                  fx;
   logic [15:0]                  fy;
   jdpm_pkg::norm_pair_type      nrm_ff [NRM_LEN];
   jdpm_pkg::norm_pair_type      nrm_w;
   jdpm_pkg::norm_pair_type      nrm_last;
   logic [15:0]                  wabs_x;
   logic [15:0]                  wabs_y;
   logic [29:0]                  wx_ff;
   logic [29:0]                  wy_ff;
   logic [59:0]                  wxsq_ff;
   logic [59:0]                  wysq_ff;
   logic [59:0]                  wsum_ff;
   logic [29:0]                  r29;
   logic signed [15:0]           cord_ang;
   logic signed [15:0]           ang_ff [ANG_LEN];
   logic [30:0]                  rad_sum;
   logic [15:0]                  rad_q;
   logic [14:0]                  rad_in;
   logic signed [15:0]           ang_in;
   logic signed [15:0]           out_nx_ff;
   logic signed [15:0]           out_ny_ff;
   logic [14:0]                  out_rad_ff;
   logic signed [15:0]           out_ang_ff;
   logic [63:0]                  out_data;
   logic                         skid_valid_ff;
   logic                         skid_valid_in;
   logic [63:0]                  skid_data_ff;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= jdpm_pkg::DEAD_ZONE_RESET;
      end else if (csr_wr_en) begin
         dead_zone_ff <= csr_wr_data;
      end
   end

   // The whole pipeline steps together unless the skid register is full.
   assign en         = ~skid_valid_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[OUT_T-2:0], req_tvalid};
      end
   end

   // Dead zone and scaling, one divider per axis.
   jdpm_dead_zone u_dz_x (
      .clock     (clock),
      .en        (en),
      .raw       (signed'(req_tdata[15:0])),
      .dead_zone (dead_zone_ff),
      .norm      (nx_dz)
   );

   jdpm_dead_zone u_dz_y (
      .clock     (clock),
      .en        (en),
      .raw       (signed'(req_tdata[31:16])),
      .dead_zone (dead_zone_ff),
      .norm      (ny_dz)
   );

   // Normalized pair delay line; y takes its sign reversal here.
   always_ff @(posedge clock) begin
      if (en) begin
         nrm_ff[0].x <= nx_dz;
         nrm_ff[0].y <= -ny_dz;
         for (int j = 1; j < NRM_LEN; j++) begin
            nrm_ff[j] <= nrm_ff[j-1];
         end
      end
   end

   // Squares of the axis magnitudes, then the warp-factor arguments.
   assign abs_x = nx_dz[15] ? 16'(-nx_dz) : 16'(nx_dz);
   assign abs_y = ny_dz[15] ? 16'(-ny_dz) : 16'(ny_dz);

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff   <= abs_x[14:0] * abs_x[14:0];
         sqy_ff   <= abs_y[14:0] * abs_y[14:0];
         argfx_ff <= 32'h4000_0000 - 32'({sqy_ff, 1'b0});
         argfy_ff <= 32'h4000_0000 - 32'({sqx_ff, 1'b0});
      end
   end

   jdpm_isqrt #(.W(32)) u_sqrt_fx (
      .clock (clock),
      .en    (en),
      .arg   (argfx_ff),
      .root  (fx)
   );

   jdpm_isqrt #(.W(32)) u_sqrt_fy (
      .clock (clock),
      .en    (en),
      .arg   (argfy_ff),
      .root  (fy)
   );

   // Warped magnitudes in Q29.
   assign nrm_w  = nrm_ff[TAP-1];
   assign wabs_x = nrm_w.x[15] ? 16'(-nrm_w.x) : 16'(nrm_w.x);
   assign wabs_y = nrm_w.y[15] ? 16'(-nrm_w.y) : 16'(nrm_w.y);

   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= 30'(wabs_x[14:0] * fx);
         wy_ff <= 30'(wabs_y[14:0] * fy);
      end
   end

   // Radius: sum of squares, then a pipelined square root.
   always_ff @(posedge clock) begin
      if (en) begin
         wxsq_ff <= 60'(wx_ff * wx_ff);
         wysq_ff <= 60'(wy_ff * wy_ff);
         wsum_ff <= wxsq_ff + wysq_ff;
      end
   end

   jdpm_isqrt #(.W(60)) u_sqrt_r (
      .clock (clock),
      .en    (en),
      .arg   (wsum_ff),
      .root  (r29)
   );

   // Angle of the warped point, then a delay to line up with the radius.
   jdpm_cordic u_cordic (
      .clock (clock),
      .en    (en),
      .wx    (wx_ff),
      .wy    (wy_ff),
      .x_neg (nrm_ff[TAP].x[15]),
      .y_neg (nrm_ff[TAP].y[15]),
      .angle (cord_ang)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff[0] <= cord_ang;
         for (int j = 1; j < ANG_LEN; j++) begin
            ang_ff[j] <= ang_ff[j-1];
         end
      end
   end

   // Output stage: radius rounding and the angle on the axes.
   assign nrm_last = nrm_ff[NRM_LEN-1];
   assign rad_sum  = 31'(r29) + 31'(jdpm_pkg::Q14_ONE);
   assign rad_q    = rad_sum[30:15];
   assign rad_in   = (rad_q > 16'(jdpm_pkg::Q14_ONE)) ? jdpm_pkg::Q14_ONE : rad_q[14:0];

   always_comb begin
      if (nrm_last.x == 16'sd0 && nrm_last.y == 16'sd0) begin
         ang_in = '0;
      end else if (nrm_last.y == 16'sd0) begin
         // On the x axis; the negative side reads as -pi.
         ang_in = (nrm_last.x > 16'sd0) ? 16'sd0 : -signed'(jdpm_pkg::ANGLE_MAX);
      end else if (nrm_last.x == 16'sd0) begin
         ang_in = (nrm_last.y > 16'sd0) ? signed'(jdpm_pkg::HALF_PI_OUT)
                                        : -signed'(jdpm_pkg::HALF_PI_OUT);
      end else begin
         ang_in = ang_ff[ANG_LEN-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_nx_ff  <= nrm_last.x;
         out_ny_ff  <= nrm_last.y;
         out_rad_ff <= rad_in;
         out_ang_ff <= ang_in;
      end
   end

   assign out_data = {1'b0, out_ang_ff, out_rad_ff, out_ny_ff, out_nx_ff};

   // Skid register catches the last stage when the receiver stalls.
   always_comb begin
      if (skid_valid_ff) begin
         skid_valid_in = ~rsp_tready;
      end else begin
         skid_valid_in = vld_ff[OUT_T-1] & ~rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_data_ff <= out_data;
      end
   end

   assign rsp_tvalid = skid_valid_ff | vld_ff[OUT_T-1];
   assign rsp_tdata  = skid_valid_ff ? skid_data_ff : out_data;

   // A stalled result in the last stage must land in the skid register.
   `JDPM_ASSERT_NEXT(a_skid_load, clock, reset,
      !skid_valid_ff && vld_ff[OUT_T-1] && !rsp_tready, skid_valid_ff,
      "stalled result was not captured")
   // The pipeline is frozen while the skid register holds a result.
   `JDPM_ASSERT_NEXT(a_frozen, clock, reset, skid_valid_ff,
      $stable(vld_ff) && $stable(out_data), "pipeline moved while skid was full")
   // The radius never exceeds 1.0.
   `JDPM_ASSERT_SAME(a_rad_range, clock, reset, vld_ff[OUT_T-1],
      out_rad_ff <= jdpm_pkg::Q14_ONE, "radius out of range")
   // The angle stays within plus or minus pi.
   `JDPM_ASSERT_SAME(a_ang_range, clock, reset, vld_ff[OUT_T-1],
      out_ang_ff <= signed'(jdpm_pkg::ANGLE_MAX) &&
      out_ang_ff >= -signed'(jdpm_pkg::ANGLE_MAX), "angle out of range")

endmodule

>>> verif/tb_joystick_deadzone_polar_map_unit.sv
`timescale 1ns / 1ps

module tb_joystick_deadzone_polar_map_unit;

   localparam int LATENCY = 69;
   localparam int RANDOM_ITEMS = 1000;

   typedef struct packed {
      logic signed [15:0] raw_y;
      logic signed [15:0] raw_x;
   } sample_pair_type;

   typedef struct packed {
      logic               pad;
      logic signed [15:0] angle;
      logic [14:0]        radius;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_x;
   } polar_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        csr_wr_en;
   logic [14:0] csr_wr_data;

   // Predictor copy of the dead zone register.
   logic [14:0] model_dead_zone;

   sample_pair_type  pending_samples[$];
   polar_result_type expected_results[$];

   int error_count;
   int sent_count;
   int received_count;
   int sender_idle_pct;
   int receiver_idle_pct;
   int hold_cycles;
   bit in_fire;

   joystick_deadzone_polar_map_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Floored integer square root of a 64-bit value.
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Floor shift right for signed values.
   function automatic longint floor_shift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -((-v - 1) >>> s) - 1;
   endfunction

   // Dead zone and Q14 scaling of one axis.
   function automatic int scale_axis(int v, int dz);
      longint d;
      longint num;
      d = 32767 - dz;
      if (v > dz) begin
         num = v - dz;
         return int'((num * 16384 + d / 2) / d);
      end
      if (v < -(dz + 1)) begin
         num = -longint'(v) - dz - 1;
         return -int'((num * 16384 + d / 2) / d);
      end
      return 0;
   endfunction

   // First-quadrant vectoring CORDIC, result in units of 2^-20 rad.
   function automatic longint quadrant_angle(longint x, longint y);
      longint z;
      longint xs;
      longint ys;
      z = 0;
      for (int i = 0; i < jdpm_pkg::CORDIC_ITERS; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(jdpm_pkg::ATAN_TAB[i]);
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(jdpm_pkg::ATAN_TAB[i]);
         end
      end
      return z;
   endfunction

   // Expected polar result for one sample pair at the current dead zone.
   function automatic polar_result_type predict_polar(sample_pair_type s);
      polar_result_type r;
      int              nx;
      int              ny;
      longint unsigned ax;
      longint unsigned ay;
      longint unsigned sx;
      longint unsigned sy;
      longint unsigned wx;
      longint unsigned wy;
      longint unsigned rad;
      longint          a;
      longint          mag;
      int              ang;
      nx = scale_axis(int'(s.raw_x), int'(model_dead_zone));
      ny = -scale_axis(int'(s.raw_y), int'(model_dead_zone));
      ax = (nx < 0) ? -nx : nx;
      ay = (ny < 0) ? -ny : ny;
      sx = int_sqrt((64'd1 << 30) - 2 * ay * ay);
      sy = int_sqrt((64'd1 << 30) - 2 * ax * ax);
      wx = ax * sx;
      wy = ay * sy;
      rad = (int_sqrt(wx * wx + wy * wy) + (64'd1 << 14)) >> 15;
      if (rad > 16384) rad = 16384;
      if (wx == 0 && wy == 0) begin
         ang = 0;
      end else if (wy == 0) begin
         ang = (nx > 0) ? 0 : -int'(jdpm_pkg::ANGLE_MAX);
      end else if (wx == 0) begin
         ang = (ny > 0) ? int'(jdpm_pkg::HALF_PI_OUT) : -int'(jdpm_pkg::HALF_PI_OUT);
      end else begin
         a = quadrant_angle(longint'(wx), longint'(wy));
         if (a < 0) a = 0;
         mag = (nx < 0) ? longint'(jdpm_pkg::PI_Q20) - a : a;
         if (mag < 0) mag = 0;
         mag = (mag + 64) >>> 7;
         if (mag > longint'(jdpm_pkg::ANGLE_MAX)) mag = longint'(jdpm_pkg::ANGLE_MAX);
         ang = (ny < 0) ? -int'(mag) : int'(mag);
      end
      r.pad = 1'b0;
      r.norm_x = nx[15:0];
      r.norm_y = ny[15:0];
      r.radius = rad[14:0];
      r.angle = ang[15:0];
      return r;
   endfunction

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      $display("mismatch on result %0d: %s got %0d expected %0d",
               received_count, what, got, want);
   endtask

   function automatic logic [15:0] random_axis();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 64)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   // Input acceptance is taken at the rising edge and predicted there.
   always @(posedge clock) begin
      in_fire = !reset && req_tvalid && req_tready;
      if (in_fire) begin
         expected_results.push_back(predict_polar(pending_samples.pop_front()));
         sent_count++;
      end
   end

   // Driver: offers the oldest pending pair and holds it until accepted.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || in_fire) begin
         if (pending_samples.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_samples[0];
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver ready, with random stalls and a counted long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // Monitor: compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      polar_result_type got;
      polar_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_results.size() == 0) begin
            error_count++;
            $display("unexpected result transaction %h", rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            if (got.norm_x !== want.norm_x) report_mismatch("norm_x", got.norm_x, want.norm_x);
            if (got.norm_y !== want.norm_y) report_mismatch("norm_y", got.norm_y, want.norm_y);
            if (got.radius !== want.radius) report_mismatch("radius", got.radius, want.radius);
            if (got.angle !== want.angle) report_mismatch("angle", got.angle, want.angle);
            if (got.pad !== 1'b0) report_mismatch("pad", got.pad, 0);
         end
         received_count++;
      end
   end

   // Waits until every queued pair is sent and every result has arrived.
   task automatic drain();
      while (pending_samples.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // Writes the dead zone register while the block is idle.
   task automatic write_dead_zone(logic [14:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      model_dead_zone = value;
   endtask

   task automatic queue_pair(logic [15:0] x, logic [15:0] y);
      sample_pair_type s;
      s.raw_x = x;
      s.raw_y = y;
      pending_samples.push_back(s);
   endtask

   task automatic queue_random(int count);
      repeat (count) queue_pair(random_axis(), random_axis());
   endtask

   // Main sequence.
   initial begin
      logic [15:0] dz16;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      error_count = 0;
      sent_count = 0;
      received_count = 0;
      sender_idle_pct = 30;
      receiver_idle_pct = 57;
      hold_cycles = 0;
      model_dead_zone = jdpm_pkg::DEAD_ZONE_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed pairs at the reset dead zone: extremes, axes, origin, edges.
      dz16 = {1'b0, model_dead_zone};
      queue_pair(16'h0000, 16'h0000);
      queue_pair(16'h7FFF, 16'h0000);
      queue_pair(16'h8000, 16'h0000);
      queue_pair(16'h0000, 16'h7FFF);
      queue_pair(16'h0000, 16'h8000);
      queue_pair(16'h7FFF, 16'h7FFF);
      queue_pair(16'h8000, 16'h8000);
      queue_pair(16'h7FFF, 16'h8000);
      queue_pair(16'h8000, 16'h7FFF);
      queue_pair(dz16, dz16 + 16'd1);
      queue_pair(-dz16 - 16'd1, -dz16 - 16'd2);
      queue_pair(dz16 + 16'd1, -dz16 - 16'd2);
      queue_pair(16'h5555, 16'hAAAA);
      queue_pair(16'hAAAA, 16'h5555);
      queue_pair(16'hFFFF, 16'h0001);
      drain();

      // Dead zone at zero and at full scale, the top of the range.
      write_dead_zone(15'd0);
      queue_pair(16'h0001, 16'hFFFF);
      queue_pair(16'hFFFE, 16'h0000);
      queue_pair(16'h0000, 16'hFFFE);
      queue_pair(16'h7FFF, 16'h8000);
      queue_random(20);
      drain();
      write_dead_zone(15'h7FFF);
      queue_pair(16'h7FFF, 16'h8000);
      queue_random(10);
      drain();

      // Long receiver hold-off while the sender keeps offering.
      write_dead_zone(15'd32000);
      hold_cycles = 400;
      queue_random(200);
      wait (hold_cycles == 0);
      drain();

      // Random phases at several dead zone settings and idle patterns.
      write_dead_zone(15'($urandom_range(0, 8000)));
      queue_random(RANDOM_ITEMS / 4);
      drain();
      sender_idle_pct = 57;
      receiver_idle_pct = 30;
      write_dead_zone(15'($urandom_range(0, 32767)));
      queue_random(RANDOM_ITEMS / 4);
      drain();
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      write_dead_zone(15'd1);
      queue_random(RANDOM_ITEMS / 4);
      drain();
      write_dead_zone(jdpm_pkg::DEAD_ZONE_RESET);
      queue_random(RANDOM_ITEMS / 8);
      drain();

      $display("Sent %0d sample pairs, checked %0d polar results across dead zone settings",
               sent_count, received_count);
      $display("including full scale, zero and a long result stall.");
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Run time limit.
   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/jdpm_pkg.sv
rtl/jdpm_dead_zone.sv
rtl/jdpm_isqrt.sv
rtl/jdpm_cordic.sv
rtl/joystick_deadzone_polar_map_unit.sv
verif/tb_joystick_deadzone_polar_map_unit.sv
